FILE: rtl/mbrs_pkg.sv
package mbrs_pkg;

    localparam int RX_DEPTH      = 256;
    localparam int RX_AW         = $clog2(RX_DEPTH);
    localparam int REG_AW        = 8;
    localparam int MAX_READ_REGS = 22;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SLAVE_ADDR_RST = 8'd8;
    localparam logic [7:0] TIMEOUT_RST    = 8'd10;
    localparam logic [7:0] COIL_ADDR      = 8'd1;
    localparam logic [7:0] COIL_ON        = 8'hFF;
    localparam logic [7:0] COIL_OFF       = 8'h00;

    localparam logic [7:0] FC_READ_COILS  = 8'd1;
    localparam logic [7:0] FC_READ_REGS   = 8'd3;
    localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FC_WRITE_REG   = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_WR_HI,
        ST_WR_LO,
        ST_WR_REG,
        ST_RD,
        ST_EMIT
    } mbrs_state_t;

    // One byte through the reflected Modbus CRC-16.
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] x;
        x = c ^ {8'h00, d};
        for (int b = 0; b < 8; b++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

FILE: rtl/modbus_rtu_slave.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------
// input    | in_valid / in_ready     | op, rx_byte, parity_error
// output   | out_valid / out_ready   | tx_byte, tx_last
// config   | cfg_we (no wait)        | cfg_index, cfg_wdata
//
// A tick is handled in ST_IDLE. A stored byte is written to the receive buffer
// and folded into the running CRC in ST_IDLE, then the frame is tested in ST_TEST.
// A completed frame then blocks input while it is served: function 16 steps
// through ST_WR_HI, ST_WR_LO and ST_WR_REG per register on the receive buffer's
// single read port, and a register read reply adds ST_RD per register for the
// holding register memory read; every response byte waits for the output register.
// Reset clears all control state and the holding register valid bits at once.
module modbus_rtu_slave
    import mbrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] rx_byte,
    input  logic       parity_error,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       tx_last,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata
);

    mbrs_state_t state_reg, state_next;

    logic [RX_AW:0]  rx_count_reg, rx_count_next;
    logic [7:0]      idle_reg, idle_next;
    logic            bad_reg, bad_next;
    logic [15:0]     crc_reg, crc_next;
    logic            coil_reg, coil_next;
    logic [7:0]      slave_reg, slave_next;
    logic [7:0]      tmo_reg, tmo_next;
    logic [5:0]      k_reg, k_next;
    logic [7:0]      j_reg, j_next;
    logic [7:0]      hi_reg, hi_next;
    logic [15:0]     tcrc_reg, tcrc_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      tx_byte_reg, tx_byte_next;
    logic            tx_last_reg, tx_last_next;
    logic [255:0]    hv_reg, hv_next;

    // Head of the current frame (bytes 0..7), captured as the bytes arrive.
    logic [7:0] sh_reg [8];
    logic [7:0] sh_next [8];

    // Receive buffer memory.
    logic [7:0]       rx_mem [RX_DEPTH];
    logic [7:0]       rx_rdata_reg;
    logic             rx_we;
    logic [RX_AW-1:0] rx_waddr;
    logic [RX_AW-1:0] rx_raddr;

    // Holding register memory; an entry never written reads as zero.
    logic [15:0]       hr_mem [2**REG_AW];
    logic [15:0]       hr_rdata_reg;
    logic              hr_rvalid_reg;
    logic              hr_we;
    logic [REG_AW-1:0] hr_waddr;
    logic [15:0]       hr_wdata;
    logic [REG_AW-1:0] hr_raddr;

    // Frame test terms.
    logic [7:0] fc;
    logic [7:0] qty;
    logic       frame_done;
    logic       frame_ok;

    // Response byte generator terms.
    logic [5:0]  data_len;
    logic        has_crc;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic        emit_rd;
    logic [5:0]  kd;
    logic [5:0]  kn;
    logic [5:0]  kdn;
    logic [7:0]  coil_idx;
    logic [15:0] rd_val;
    logic        out_free;

    assign fc  = sh_reg[1];
    assign qty = sh_reg[5];

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign tx_last   = tx_last_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Frame test. The count only grows by one between tests, so a frame is
    // complete exactly when the count equals its length. The CRC over a whole
    // frame, its own CRC included, is zero exactly when the CRC matches.
    always_comb
    begin
        frame_done = 1'b0;
        unique case (fc) inside
            FC_READ_COILS, FC_READ_REGS, FC_WRITE_COIL, FC_WRITE_REG:
            begin
                frame_done = (rx_count_reg == (RX_AW+1)'(8));
            end
            FC_WRITE_COILS:
            begin
                frame_done = (rx_count_reg >= (RX_AW+1)'(9)) &&
                             (10'(rx_count_reg) == 10'(sh_reg[6]) + 10'd9);
            end
            FC_WRITE_REGS:
            begin
                frame_done = (sh_reg[4] == 8'h00) &&
                             (10'(rx_count_reg) == {1'b0, qty, 1'b0} + 10'd9);
            end
            default:
            begin
                frame_done = 1'b0;
            end
        endcase
        if (rx_count_reg <= (RX_AW+1)'(4))
        begin
            frame_done = 1'b0;
        end
        frame_ok = (sh_reg[0] == slave_reg) && !bad_reg && (crc_reg == 16'h0000);
    end

    // Response bytes: header, data by function, then CRC low and high.
    // Echo replies (functions 5 and 6) resend the received eight bytes.
    always_comb
    begin
        has_crc  = (fc != FC_WRITE_COIL) && (fc != FC_WRITE_REG);
        data_len = 6'd8;
        case (fc)
            FC_READ_COILS:  data_len = 6'd3 + 6'((9'(qty) + 9'd7) >> 3);
            FC_READ_REGS:   data_len = 6'd3 + 6'({qty, 1'b0});
            FC_WRITE_REGS:  data_len = 6'd6;
            default:        data_len = 6'd8;
        endcase

        kd       = k_reg - 6'd3;
        kn       = k_reg + 6'd1;
        kdn      = kn - 6'd3;
        coil_idx = COIL_ADDR - sh_reg[3];
        rd_val   = hr_rvalid_reg ? hr_rdata_reg : 16'h0000;

        emit_byte = 8'h00;
        if (has_crc && k_reg == data_len)
        begin
            emit_byte = tcrc_reg[7:0];
        end
        else if (has_crc && k_reg == data_len + 6'd1)
        begin
            emit_byte = tcrc_reg[15:8];
        end
        else if (!has_crc)
        begin
            emit_byte = sh_reg[k_reg[2:0]];
        end
        else if (k_reg == 6'd0)
        begin
            emit_byte = slave_reg;
        end
        else if (k_reg == 6'd1)
        begin
            emit_byte = fc;
        end
        else
        begin
            case (fc)
                FC_READ_COILS:
                begin
                    if (k_reg == 6'd2)
                    begin
                        emit_byte = 8'(data_len - 6'd3);
                    end
                    else if (coil_reg && coil_idx < qty && 6'(coil_idx[7:3]) == kd)
                    begin
                        emit_byte = 8'd1 << coil_idx[2:0];
                    end
                end
                FC_READ_REGS:
                begin
                    if (k_reg == 6'd2)
                    begin
                        emit_byte = {qty[6:0], 1'b0};
                    end
                    else
                    begin
                        emit_byte = kd[0] ? rd_val[7:0] : rd_val[15:8];
                    end
                end
                FC_WRITE_REGS:
                begin
                    if (k_reg == 6'd3)
                    begin
                        emit_byte = sh_reg[3];
                    end
                    else if (k_reg == 6'd5)
                    begin
                        emit_byte = qty;
                    end
                end
                default:
                begin
                    emit_byte = 8'h00;
                end
            endcase
        end

        emit_last = has_crc ? (k_reg == data_len + 6'd1) : (k_reg == data_len - 6'd1);
        emit_rd   = (fc == FC_READ_REGS) && (kn >= 6'd3) && (kn < data_len) && !kdn[0];
    end

    always_comb
    begin
        state_next     = state_reg;
        rx_count_next  = rx_count_reg;
        idle_next      = idle_reg;
        bad_next       = bad_reg;
        crc_next       = crc_reg;
        coil_next      = coil_reg;
        slave_next     = slave_reg;
        tmo_next       = tmo_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        hi_next        = hi_reg;
        tcrc_next      = tcrc_reg;
        out_valid_next = out_valid_reg;
        tx_byte_next   = tx_byte_reg;
        tx_last_next   = tx_last_reg;
        hv_next        = hv_reg;
        sh_next        = sh_reg;

        rx_we    = 1'b0;
        rx_waddr = rx_count_reg[RX_AW-1:0];
        rx_raddr = 8'd7 + {j_reg[6:0], 1'b0};
        hr_we    = 1'b0;
        hr_waddr = sh_reg[3] + j_reg;
        hr_wdata = {hi_reg, rx_rdata_reg};
        hr_raddr = sh_reg[3] + 8'(kd >> 1);

        // Drop the output byte once it is taken.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            if (cfg_index == CFG_SLAVE_ADDR)
            begin
                slave_next = cfg_wdata;
            end
            else
            begin
                tmo_next = cfg_wdata;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_TICK)
                    begin
                        // Count down; on expiry empty a partly received frame.
                        if (idle_reg != 8'd0)
                        begin
                            idle_next = idle_reg - 8'd1;
                            if (idle_reg == 8'd1 && rx_count_reg != '0)
                            begin
                                rx_count_next = '0;
                                bad_next      = 1'b0;
                                crc_next      = CRC_INIT;
                            end
                        end
                    end
                    else
                    begin
                        idle_next = tmo_reg;
                        // A full buffer drops the byte without a test.
                        if (!rx_count_reg[RX_AW])
                        begin
                            rx_we = 1'b1;
                            if (rx_count_reg < (RX_AW+1)'(8))
                            begin
                                sh_next[rx_count_reg[2:0]] = rx_byte;
                            end
                            rx_count_next = rx_count_reg + (RX_AW+1)'(1);
                            bad_next      = bad_reg | parity_error;
                            crc_next      = crc16_byte(crc_reg, rx_byte);
                            state_next    = ST_TEST;
                        end
                    end
                end
            end

            ST_TEST:
            begin
                state_next = ST_IDLE;
                if (frame_done)
                begin
                    rx_count_next = '0;
                    bad_next      = 1'b0;
                    crc_next      = CRC_INIT;
                    tcrc_next     = CRC_INIT;
                    k_next        = 6'd0;
                    j_next        = 8'd0;
                    if (frame_ok)
                    begin
                        case (fc)
                            FC_READ_COILS:
                            begin
                                state_next = ST_EMIT;
                            end
                            FC_READ_REGS:
                            begin
                                // Oversized reads get no reply.
                                if (qty <= 8'(MAX_READ_REGS))
                                begin
                                    state_next = ST_EMIT;
                                end
                            end
                            FC_WRITE_COIL:
                            begin
                                if (sh_reg[3] == COIL_ADDR)
                                begin
                                    if (sh_reg[4] == COIL_ON)
                                    begin
                                        coil_next = 1'b1;
                                    end
                                    else if (sh_reg[4] == COIL_OFF)
                                    begin
                                        coil_next = 1'b0;
                                    end
                                end
                                state_next = ST_EMIT;
                            end
                            FC_WRITE_REG:
                            begin
                                hr_we    = 1'b1;
                                hr_waddr = sh_reg[3];
                                hr_wdata = {sh_reg[4], sh_reg[5]};
                                hv_next[sh_reg[3]] = 1'b1;
                                state_next = ST_EMIT;
                            end
                            FC_WRITE_REGS:
                            begin
                                state_next = (qty == 8'd0) ? ST_EMIT : ST_WR_HI;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            // Fetch the register's high byte from the receive buffer.
            ST_WR_HI:
            begin
                state_next = ST_WR_LO;
            end

            ST_WR_LO:
            begin
                hi_next    = rx_rdata_reg;
                rx_raddr   = 8'd8 + {j_reg[6:0], 1'b0};
                state_next = ST_WR_REG;
            end

            ST_WR_REG:
            begin
                hr_we   = 1'b1;
                hv_next[hr_waddr] = 1'b1;
                j_next  = j_reg + 8'd1;
                state_next = (8'(j_reg + 8'd1) == qty) ? ST_EMIT : ST_WR_HI;
            end

            // Holding register read; data is there for the next byte.
            ST_RD:
            begin
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = emit_byte;
                    tx_last_next   = emit_last;
                    // Hold the CRC once its own bytes go out.
                    if (k_reg < data_len)
                    begin
                        tcrc_next = crc16_byte(tcrc_reg, emit_byte);
                    end
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = kn;
                        if (emit_rd)
                        begin
                            state_next = ST_RD;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rx_count_reg  <= '0;
            idle_reg      <= 8'd0;
            bad_reg       <= 1'b0;
            crc_reg       <= CRC_INIT;
            coil_reg      <= 1'b0;
            slave_reg     <= SLAVE_ADDR_RST;
            tmo_reg       <= TIMEOUT_RST;
            k_reg         <= 6'd0;
            j_reg         <= 8'd0;
            out_valid_reg <= 1'b0;
            hv_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rx_count_reg  <= rx_count_next;
            idle_reg      <= idle_next;
            bad_reg       <= bad_next;
            crc_reg       <= crc_next;
            coil_reg      <= coil_next;
            slave_reg     <= slave_next;
            tmo_reg       <= tmo_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            hv_reg        <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg      <= hi_next;
        tcrc_reg    <= tcrc_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
        sh_reg      <= sh_next;
    end

    // Receive buffer: written only while idle, read only while serving,
    // so the two ports never meet on one entry.
    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_waddr] <= rx_byte;
        end
        rx_rdata_reg <= rx_mem[rx_raddr];
    end

    // Holding registers: writes fall in ST_TEST and ST_WR_REG, reads for a reply in ST_RD and ST_EMIT.
    always_ff @(posedge clk)
    begin
        if (hr_we)
        begin
            hr_mem[hr_waddr] <= hr_wdata;
        end
        hr_rdata_reg  <= hr_mem[hr_raddr];
        hr_rvalid_reg <= hv_reg[hr_raddr];
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= (RX_AW+1)'(RX_DEPTH))
        else $error("receive count past buffer depth");

    a_rd_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |=> state_reg == ST_EMIT)
        else $error("register read not followed by emit");

    a_test_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST && frame_done) |=> rx_count_reg == '0)
        else $error("completed frame left bytes in buffer");

    a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT || state_reg == ST_WR_REG) |-> !in_ready)
        else $error("input taken while serving a request");
`endif

endmodule

FILE: tb/tb_modbus_rtu_slave.sv
module tb_modbus_rtu_slave;
    import mbrs_pkg::*;

    // Predicts the slave byte by byte and holds the response bytes still owed.
    class mb_scoreboard;
        bit [7:0]  rx_buf [256];
        int        rx_n;
        bit [7:0]  idle_n;
        bit        bad;
        bit [15:0] regs [256];
        bit        coil;
        bit [7:0]  own_addr;
        bit [7:0]  tmo;
        bit [8:0]  owed_q [$];
        int        errors;
        int        replies;

        function new();
            rx_n     = 0;
            idle_n   = 0;
            bad      = 0;
            coil     = 0;
            own_addr = SLAVE_ADDR_RST;
            tmo      = TIMEOUT_RST;
            errors   = 0;
            replies  = 0;
            foreach (regs[i])
                regs[i] = 16'h0000;
            foreach (rx_buf[i])
                rx_buf[i] = 8'h00;
        endfunction

        static function bit [15:0] crc16(input bit [7:0] d [$]);
            bit [15:0] c;
            c = 16'hFFFF;
            foreach (d[i])
            begin
                c ^= {8'h00, d[i]};
                for (int b = 0; b < 8; b++)
                    c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            end
            return c;
        endfunction

        function void owe(input bit [7:0] tx [$], input bit add_crc);
            bit [15:0] c;
            if (add_crc)
            begin
                c = crc16(tx);
                tx.push_back(c[7:0]);
                tx.push_back(c[15:8]);
            end
            foreach (tx[k])
                owed_q.push_back({tx[k], k == tx.size() - 1});
            replies++;
        endfunction

        function void serve(input bit [7:0] fc);
            bit [7:0]  tx [$];
            bit [7:0]  base;
            int        cnt;
            int        nb;
            bit [15:0] v;
            base = rx_buf[3];
            cnt  = rx_buf[5];
            tx   = {own_addr, fc};
            case (fc)
                FC_READ_COILS:
                begin
                    nb = (cnt + 7) / 8;
                    tx.push_back(nb[7:0]);
                    for (int i = 0; i < nb; i++)
                        tx.push_back(8'h00);
                    for (int i = 0; i < cnt; i++)
                        if (8'(base + i) == COIL_ADDR && coil)
                            tx[3 + i / 8] |= 8'(1 << (i % 8));
                    owe(tx, 1);
                end
                FC_READ_REGS:
                begin
                    if (cnt <= MAX_READ_REGS && 5 + 2 * cnt <= 49)
                    begin
                        tx.push_back(8'(2 * cnt));
                        for (int i = 0; i < cnt; i++)
                        begin
                            v = regs[8'(base + i)];
                            tx.push_back(v[15:8]);
                            tx.push_back(v[7:0]);
                        end
                        owe(tx, 1);
                    end
                end
                FC_WRITE_COIL:
                begin
                    if (base == COIL_ADDR)
                    begin
                        if (rx_buf[4] == COIL_ON)
                            coil = 1;
                        else if (rx_buf[4] == COIL_OFF)
                            coil = 0;
                    end
                    tx = {};
                    for (int i = 0; i < 8; i++)
                        tx.push_back(rx_buf[i]);
                    owe(tx, 0);
                end
                FC_WRITE_REG:
                begin
                    regs[base] = {rx_buf[4], rx_buf[5]};
                    tx = {};
                    for (int i = 0; i < 8; i++)
                        tx.push_back(rx_buf[i]);
                    owe(tx, 0);
                end
                FC_WRITE_REGS:
                begin
                    for (int i = 0; i < cnt; i++)
                        regs[8'(base + i)] = {rx_buf[7 + 2 * i], rx_buf[8 + 2 * i]};
                    tx.push_back(8'h00);
                    tx.push_back(base);
                    tx.push_back(8'h00);
                    tx.push_back(8'(cnt));
                    owe(tx, 1);
                end
                default: ;
            endcase
        endfunction

        function void test_frame();
            bit [7:0]  fc;
            int        need;
            bit [7:0]  body [$];
            bit [15:0] c;
            bit        ok;
            if (rx_n <= 4)
                return;
            fc = rx_buf[1];
            case (fc)
                FC_READ_COILS, FC_READ_REGS, FC_WRITE_COIL, FC_WRITE_REG: need = 8;
                FC_WRITE_COILS:
                begin
                    if (rx_n < 9)
                        return;
                    need = rx_buf[6] + 9;
                end
                FC_WRITE_REGS: need = 2 * {rx_buf[4], rx_buf[5]} + 9;
                default: return;
            endcase
            if (rx_n < need)
                return;
            for (int i = 0; i < need - 2; i++)
                body.push_back(rx_buf[i]);
            c  = crc16(body);
            ok = rx_buf[0] == own_addr && !bad &&
                 rx_buf[need - 2] == c[7:0] && rx_buf[need - 1] == c[15:8];
            rx_n = 0;
            bad  = 0;
            if (ok && fc != FC_WRITE_COILS)
                serve(fc);
        endfunction

        // Note one accepted request.
        function void note_request(input bit o, input bit [7:0] b, input bit p);
            if (o == OP_TICK)
            begin
                if (idle_n > 0)
                begin
                    idle_n--;
                    if (idle_n == 0 && rx_n > 0)
                    begin
                        rx_n = 0;
                        bad  = 0;
                    end
                end
                return;
            end
            idle_n = tmo;
            if (rx_n >= 256)
                return;
            rx_buf[rx_n] = b;
            rx_n++;
            if (p)
                bad = 1;
            test_frame();
        endfunction

        task report(input string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        // Check one accepted response byte against the oldest owed one.
        task check_result(input bit [7:0] b, input bit last);
            bit [8:0] e;
            if (owed_q.size() == 0)
            begin
                report($sformatf("unexpected byte %02h last %0d", b, last));
                return;
            end
            e = owed_q.pop_front();
            if (b !== e[8:1])
                report($sformatf("tx_byte %02h, want %02h", b, e[8:1]));
            if (last !== e[0])
                report($sformatf("tx_last %0d, want %0d", last, e[0]));
        endtask
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_ready;
    logic       op = 0;
    logic [7:0] rx_byte = 0;
    logic       parity_error = 0;
    logic       out_valid;
    logic       out_ready = 0;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       cfg_we = 0;
    logic       cfg_index = 0;
    logic [7:0] cfg_wdata = 0;

    mb_scoreboard sb = new();
    bit  quiet = 0;       // no idling on either side while set
    int  sent = 0;
    int  stall = 0;
    int  frames = 0;
    localparam int STALL_LIMIT = 20000;

    modbus_rtu_slave dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Receiver: drop ready now and then, sample at the rising edge.
    always @(negedge clk)
        out_ready = quiet || ($urandom_range(99) >= 13);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(tx_byte, tx_last);

    // Watchdog: cycles with no request and no response accepted.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall = 0;
        else
            stall++;
        if (stall >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("** modbus_rtu_slave: FAILED **");
            $finish;
        end
    end

    // Present one request at the falling edge and hold it until accepted.
    task send_request(input bit o, input bit [7:0] b, input bit p);
        if (!quiet && $urandom_range(99) < 13)
        begin
            in_valid = 0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        op           = o;
        rx_byte      = b;
        parity_error = p;
        in_valid     = 1;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        sb.note_request(o, b, p);
        sent++;
        @(negedge clk);
    endtask

    task send_ticks(input int n);
        repeat (n) send_request(OP_TICK, 8'($urandom), 1'($urandom));
    endtask

    // Send a frame; mode 0 good, 1 bad CRC, 2 parity error, 3 foreign address.
    task send_frame(input bit [7:0] body [$], input int mode);
        bit [15:0] c;
        int        perr;
        if (mode == 3)
            body[0] = sb.own_addr + 8'($urandom_range(255, 1));
        c = mb_scoreboard::crc16(body);
        body.push_back(c[7:0]);
        body.push_back(c[15:8] ^ (mode == 1 ? 8'($urandom_range(255, 1)) : 8'h00));
        perr = (mode == 2) ? $urandom_range(body.size() - 1) : -1;
        foreach (body[i])
        begin
            // tuck a stray tick into a frame now and then
            if ($urandom_range(99) < 3)
                send_request(OP_TICK, 8'h00, 1'b0);
            send_request(OP_BYTE, body[i], i == perr);
        end
        frames++;
        in_valid = 0;
    endtask

    function automatic bit [7:0] pick_addr();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4));
    endfunction

    // Build a request of the given function with random content.
    function automatic void build(input bit [7:0] fc, output bit [7:0] q [$]);
        int n;
        q = {sb.own_addr, fc, 8'($urandom), pick_addr()};
        case (fc)
            FC_READ_COILS:
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(20);
                q.push_back(8'($urandom));
                q.push_back(8'(n));
            end
            FC_READ_REGS:
            begin
                q.push_back(8'($urandom));
                q.push_back(8'($urandom_range(24)));
            end
            FC_WRITE_COIL:
            begin
                if ($urandom_range(1))
                    q[3] = COIL_ADDR;
                case ($urandom_range(3))
                    0: q.push_back(COIL_ON);
                    1: q.push_back(COIL_OFF);
                    default: q.push_back(8'($urandom));
                endcase
                q.push_back(8'($urandom));
            end
            FC_WRITE_REG:
            begin
                q.push_back(8'($urandom));
                q.push_back(8'($urandom));
            end
            FC_WRITE_REGS:
            begin
                n = $urandom_range(5);
                q.push_back(8'h00);
                q.push_back(8'(n));
                q.push_back(8'($urandom));
                repeat (2 * n) q.push_back(8'($urandom));
            end
            FC_WRITE_COILS:
            begin
                n = $urandom_range(4);
                q.push_back(8'($urandom));
                q.push_back(8'($urandom));
                q.push_back(8'(n));
                repeat (n) q.push_back(8'($urandom));
            end
            default: ;
        endcase
    endfunction

    task directed(input bit [7:0] fc, input bit [7:0] a, input bit [7:0] b4,
                  input bit [7:0] b5, input int mode);
        bit [7:0] q [$];
        q = {sb.own_addr, fc, 8'h00, a, b4, b5};
        send_frame(q, mode);
    endtask

    // Hold off until every owed byte is out and the block has gone quiet.
    task settle();
        in_valid = 0;
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        @(negedge clk);
    endtask

    task configure(input bit [7:0] addr, input bit [7:0] tmo);
        settle();
        cfg_we    = 1;
        cfg_index = CFG_SLAVE_ADDR;
        cfg_wdata = addr;
        @(negedge clk);
        cfg_index = CFG_TIMEOUT;
        cfg_wdata = tmo;
        @(negedge clk);
        cfg_we      = 0;
        sb.own_addr = addr;
        sb.tmo      = tmo;
    endtask

    task random_phase(input int items);
        bit [7:0] q [$];
        bit [7:0] fcs [7];
        int       stop;
        int       k;
        fcs  = '{FC_READ_COILS, FC_READ_REGS, FC_WRITE_COIL, FC_WRITE_REG,
                 FC_WRITE_REGS, FC_WRITE_COILS, 8'h00};
        stop = sent + items;
        while (sent < stop)
        begin
            k = $urandom_range(6);
            if (k == 6)
            begin
                // noise: only where a short timeout can flush it
                if (sb.tmo != 0 && sb.tmo <= 20)
                begin
                    repeat ($urandom_range(12, 1))
                        send_request(OP_BYTE, 8'($urandom), 1'($urandom));
                    send_ticks(sb.tmo);
                end
                continue;
            end
            build(fcs[k], q);
            send_frame(q, ($urandom_range(9) < 8) ? 0 : $urandom_range(3, 1));
            // pause once until the reply is fully drained
            if (frames == 20)
                settle();
        end
        in_valid = 0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed, reset configuration.
        directed(FC_READ_COILS, COIL_ADDR, 8'h00, 8'd1, 0);
        directed(FC_WRITE_COIL, COIL_ADDR, COIL_ON, 8'h00, 0);
        directed(FC_READ_COILS, 8'h00, 8'h00, 8'd255, 0);
        directed(FC_WRITE_COIL, COIL_ADDR, 8'h12, 8'h00, 0);
        directed(FC_WRITE_COIL, 8'd2, COIL_ON, 8'h00, 0);
        directed(FC_WRITE_COIL, COIL_ADDR, COIL_OFF, 8'h00, 0);
        directed(FC_WRITE_REG, 8'd255, 8'hFF, 8'hFF, 0);
        directed(FC_WRITE_REG, 8'd0, 8'hA5, 8'h5A, 0);
        directed(FC_READ_REGS, 8'd254, 8'h00, 8'd3, 0);
        directed(FC_READ_REGS, 8'd0, 8'h00, 8'd22, 0);
        directed(FC_READ_REGS, 8'd0, 8'h00, 8'd23, 0);
        directed(FC_READ_REGS, 8'd0, 8'h00, 8'd2, 1);
        directed(FC_WRITE_REG, 8'd3, 8'h11, 8'h22, 2);
        directed(FC_WRITE_REG, 8'd3, 8'h11, 8'h22, 3);
        send_frame('{SLAVE_ADDR_RST, FC_WRITE_REGS, 8'h00, 8'd255, 8'h00, 8'd2, 8'd4,
                     8'hDE, 8'hAD, 8'hBE, 8'hEF}, 0);
        send_frame('{SLAVE_ADDR_RST, FC_WRITE_COILS, 8'h00, 8'd1, 8'h00, 8'd8, 8'd1,
                     8'hFF}, 0);
        directed(FC_READ_REGS, 8'd255, 8'h00, 8'd2, 0);
        directed(8'h2B, 8'd0, 8'h00, 8'd0, 0);
        send_ticks(TIMEOUT_RST);

        configure(8'd0, 8'd1);
        random_phase(6);
        configure(8'd255, 8'd255);
        quiet = 1;
        random_phase(6);
        quiet = 0;
        configure(8'($urandom), 8'd0);
        send_ticks(3);
        random_phase(6);
        // Full buffer: an unknown function fills it, the rest is dropped.
        configure(8'($urandom), 8'd5);
        send_request(OP_BYTE, sb.own_addr, 1'b0);
        repeat (257) send_request(OP_BYTE, 8'h41, 1'($urandom));
        send_ticks(6);
        random_phase(6);
        configure(SLAVE_ADDR_RST, TIMEOUT_RST);
        random_phase(6);

        settle();
        $display("covered %0d requests in %0d frames, %0d replies, over six settings",
                 sent, frames, sb.replies);
        $display("read, write and force paths with CRC, parity, address and timeout faults");
        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("** modbus_rtu_slave: PASSED **");
        else
            $display("** modbus_rtu_slave: FAILED **");
        $finish;
    end
endmodule
